[rtl/core/particle_euler_integrator_top_defines.svh]
// Assertion macros for the particle integrator core.
// Taken in by the files that carry concurrent checks; no other dependency.
`ifndef PARTICLE_EULER_INTEGRATOR_TOP_DEFINES_SVH
`define PARTICLE_EULER_INTEGRATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PEI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PEI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/pei_pkg.sv]
// Shared types, codes and helpers for the particle integrator core.
// No dependencies; used by the interfaces, the multiply unit and the top level.
package pei_pkg;

	localparam int VAL_W  = 32;
	localparam int MASS_W = 24;
	localparam int Q16_W  = 16;
	localparam int REQ_W  = 2;
	localparam int CIDX_W = 2;
	localparam int CNT_W  = 4;

	// request codes
	localparam logic [REQ_W-1:0] REQ_FORCE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PLACE = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_INV_MASS  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_TIME_STEP = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_DAMPING   = 2'd2;

	localparam logic [MASS_W-1:0] INV_MASS_RST  = 24'd65536;
	localparam logic [Q16_W-1:0]  TIME_STEP_RST = 16'd1092;
	localparam logic [Q16_W-1:0]  DAMPING_RST   = 16'd65535;

	// multiply op kinds: what the writeback does with the product
	localparam logic [1:0] OP_POS  = 2'd0; // pos += vel*dt
	localparam logic [1:0] OP_ACC  = 2'd1; // acc = force*inv_mass, force cleared
	localparam logic [1:0] OP_VEL  = 2'd2; // vel += acc*dt
	localparam logic [1:0] OP_DAMP = 2'd3; // vel = vel*damping

	// last sequencer count of a step (final writeback lands here)
	localparam logic [CNT_W-1:0] STEP_LAST = 4'd11;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       axis; // 0 = x, 1 = y
	} pei_op_t;

	function automatic val_t sat_add32(input val_t a, input val_t b);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1])
			return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		return s[VAL_W-1:0];
	endfunction

endpackage

[rtl/core/pei_if.sv]
// Handshake channels of the particle integrator: request, result, config write.
// Depends on pei_pkg for field widths.
interface pei_req_if
	import pei_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	val_t              value_x;
	val_t              value_y;
	val_t              second_x;
	val_t              second_y;

	modport source (output valid, req_type, value_x, value_y, second_x, second_y,
		input ready);
	modport sink (input valid, req_type, value_x, value_y, second_x, second_y,
		output ready);
endinterface

interface pei_res_if
	import pei_pkg::*;
	();
	logic valid;
	logic ready;
	val_t pos_x;
	val_t pos_y;
	val_t vel_x;
	val_t vel_y;
	val_t accel_x;
	val_t accel_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, accel_x, accel_y,
		input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, accel_x, accel_y,
		output ready);
endinterface

interface pei_cfg_if
	import pei_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [MASS_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/pei_mul.sv]
// Shared multiply unit: signed value times unsigned fixed-point factor,
// round half up, saturate to 32 bits. Two register stages. Depends on pei_pkg.
module pei_mul
	import pei_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              iss_vld,
	input  pei_op_t           iss_op,
	input  val_t              opa,
	input  logic [MASS_W-1:0] opb,
	output logic              res_vld,
	output pei_op_t           res_op,
	output val_t              res_val
);

	localparam int PW = VAL_W + MASS_W + 1;
	localparam logic signed [PW:0] RND_HALF = (PW+1)'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [PW:0] MAX32 = (PW+1)'({1'b0, {(VAL_W-1){1'b1}}});
	localparam logic signed [PW:0] MIN32 = -MAX32 - (PW+1)'(1);

	logic              vld_s1;
	pei_op_t           op_s1;
	logic signed [PW-1:0] prod_s1;

	logic signed [PW:0] rnd;
	logic signed [PW:0] shf;
	val_t               sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			res_vld <= 1'b0;
		end else begin
			vld_s1  <= iss_vld;
			res_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= iss_op;
		prod_s1 <= opa * $signed({1'b0, opb});
		res_op  <= op_s1;
		res_val <= sat;
	end

	// floor((p + half) / 2^F), then clamp
	always_comb begin
		rnd = {prod_s1[PW-1], prod_s1} + RND_HALF;
		shf = rnd >>> FRACTION_BITS;
		if (shf > MAX32)
			sat = {1'b0, {(VAL_W-1){1'b1}}};
		else if (shf < MIN32)
			sat = {1'b1, {(VAL_W-1){1'b0}}};
		else
			sat = shf[VAL_W-1:0];
	end

endmodule

[rtl/core/particle_euler_integrator_top.sv]
// Particle integrator top level: state registers, sequencer, output register.
// Depends on pei_pkg, pei_if channels, pei_mul and the assertion macro header.
//
// Usage:
//  - req channel carries one item: req_type (add force, step, place) plus two
//    vectors. res channel returns one item per request: position, velocity and
//    last acceleration after that request. cfg channel writes inv_mass,
//    time_step and damping_per_step by index; it is always ready. The user must
//    ensure it is written only while the block is idle; the block does not enforce it.
//  - Add force, place and the unused code: the block goes to the hold state,
//    loads the output register and returns to idle, where the next item is taken.
//  - Step with nonzero inv_mass: eight products go one per issue slot through
//    the single pipelined multiplier; dependencies (acc before vel, vel before
//    damping) set the sequencer's issue schedule, after which the block goes to
//    the hold state. A step with zero inv_mass behaves like add/place
//    timing and changes nothing.
//  - req.ready is high only while idle; one item is in flight at a time.
//  - If res stalls, the finished item waits in the output register; a new
//    item is still taken, and its result waits in the hold state until the
//    output register frees.
//  - Reset (arst_n low) clears all particle state to zero, loads register
//    defaults and empties the output register.
`include "particle_euler_integrator_top_defines.svh"

module particle_euler_integrator_top
	import pei_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	pei_req_if.sink   req,
	pei_res_if.source res,
	pei_cfg_if.sink   cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;

	// config
	logic [MASS_W-1:0] inv_mass_q;
	logic [Q16_W-1:0]  dt_q;
	logic [Q16_W-1:0]  damp_q;

	// particle state
	val_t pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	val_t frc_x_q, frc_y_q, acc_x_q, acc_y_q;

	// output register
	logic out_vld_q;
	val_t o_pos_x_q, o_pos_y_q, o_vel_x_q, o_vel_y_q, o_acc_x_q, o_acc_y_q;

	logic req_acc;
	logic out_load;

	// multiplier issue/writeback
	logic              iss_vld;
	pei_op_t           iss_op;
	val_t              opa;
	logic [MASS_W-1:0] opb;
	logic              wb_vld;
	pei_op_t           wb_op;
	val_t              wb_val;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign out_load  = (state_q == ST_HOLD) && (!out_vld_q || res.ready);

	// issue schedule: x/y pairs, gaps wait for the writeback they depend on
	always_comb begin
		iss_vld     = 1'b0;
		iss_op.kind = OP_POS;
		iss_op.axis = 1'b0;
		unique case (cnt_q)
			4'd0: begin iss_vld = 1'b1; iss_op.kind = OP_POS;  iss_op.axis = 1'b0; end
			4'd1: begin iss_vld = 1'b1; iss_op.kind = OP_POS;  iss_op.axis = 1'b1; end
			4'd2: begin iss_vld = 1'b1; iss_op.kind = OP_ACC;  iss_op.axis = 1'b0; end
			4'd3: begin iss_vld = 1'b1; iss_op.kind = OP_ACC;  iss_op.axis = 1'b1; end
			4'd5: begin iss_vld = 1'b1; iss_op.kind = OP_VEL;  iss_op.axis = 1'b0; end
			4'd6: begin iss_vld = 1'b1; iss_op.kind = OP_VEL;  iss_op.axis = 1'b1; end
			4'd8: begin iss_vld = 1'b1; iss_op.kind = OP_DAMP; iss_op.axis = 1'b0; end
			4'd9: begin iss_vld = 1'b1; iss_op.kind = OP_DAMP; iss_op.axis = 1'b1; end
			default: iss_vld = 1'b0;
		endcase
		iss_vld = iss_vld && (state_q == ST_RUN);
	end

	// operand select
	always_comb begin
		unique case (iss_op.kind)
			OP_POS: begin
				opa = iss_op.axis ? vel_y_q : vel_x_q;
				opb = MASS_W'(dt_q);
			end
			OP_ACC: begin
				opa = iss_op.axis ? frc_y_q : frc_x_q;
				opb = inv_mass_q;
			end
			OP_VEL: begin
				opa = iss_op.axis ? acc_y_q : acc_x_q;
				opb = MASS_W'(dt_q);
			end
			default: begin
				opa = iss_op.axis ? vel_y_q : vel_x_q;
				opb = MASS_W'(damp_q);
			end
		endcase
	end

	pei_mul #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.iss_vld (iss_vld),
		.iss_op  (iss_op),
		.opa     (opa),
		.opb     (opb),
		.res_vld (wb_vld),
		.res_op  (wb_op),
		.res_val (wb_val)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req_acc) begin
						if (req.req_type == REQ_STEP && inv_mass_q != '0)
							state_q <= ST_RUN;
						else
							state_q <= ST_HOLD;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == STEP_LAST)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= INV_MASS_RST;
			dt_q       <= TIME_STEP_RST;
			damp_q     <= DAMPING_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_INV_MASS:  inv_mass_q <= cfg.data;
				CFG_TIME_STEP: dt_q       <= cfg.data[Q16_W-1:0];
				CFG_DAMPING:   damp_q     <= cfg.data[Q16_W-1:0];
				default: ;
			endcase
		end
	end

	// particle state: request updates while idle, multiply writeback while running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0; pos_y_q <= '0;
			vel_x_q <= '0; vel_y_q <= '0;
			frc_x_q <= '0; frc_y_q <= '0;
			acc_x_q <= '0; acc_y_q <= '0;
		end else if (req_acc) begin
			if (req.req_type == REQ_FORCE) begin
				frc_x_q <= sat_add32(frc_x_q, req.value_x);
				frc_y_q <= sat_add32(frc_y_q, req.value_y);
			end else if (req.req_type == REQ_PLACE) begin
				pos_x_q <= req.value_x;
				pos_y_q <= req.value_y;
				vel_x_q <= req.second_x;
				vel_y_q <= req.second_y;
			end
		end else if (wb_vld) begin
			unique case (wb_op.kind)
				OP_POS: begin
					if (wb_op.axis) pos_y_q <= sat_add32(pos_y_q, wb_val);
					else            pos_x_q <= sat_add32(pos_x_q, wb_val);
				end
				OP_ACC: begin
					if (wb_op.axis) begin
						acc_y_q <= wb_val;
						frc_y_q <= '0;
					end else begin
						acc_x_q <= wb_val;
						frc_x_q <= '0;
					end
				end
				OP_VEL: begin
					if (wb_op.axis) vel_y_q <= sat_add32(vel_y_q, wb_val);
					else            vel_x_q <= sat_add32(vel_x_q, wb_val);
				end
				default: begin
					if (wb_op.axis) vel_y_q <= wb_val;
					else            vel_x_q <= wb_val;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (res.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_pos_x_q <= pos_x_q;
			o_pos_y_q <= pos_y_q;
			o_vel_x_q <= vel_x_q;
			o_vel_y_q <= vel_y_q;
			o_acc_x_q <= acc_x_q;
			o_acc_y_q <= acc_y_q;
		end
	end

	assign res.valid   = out_vld_q;
	assign res.pos_x   = o_pos_x_q;
	assign res.pos_y   = o_pos_y_q;
	assign res.vel_x   = o_vel_x_q;
	assign res.vel_y   = o_vel_y_q;
	assign res.accel_x = o_acc_x_q;
	assign res.accel_y = o_acc_y_q;

	`PEI_ASSERT_NEXT(a_step_runs, clk, arst_n,
		req_acc && req.req_type == REQ_STEP && inv_mass_q != '0,
		state_q == ST_RUN && cnt_q == '0, "step with mass did not start sequence")
	`PEI_ASSERT_NOW(a_wb_in_run, clk, arst_n, wb_vld, state_q == ST_RUN,
		"multiply writeback outside a step")
	`PEI_ASSERT_NEXT(a_force_cleared, clk, arst_n,
		state_q == ST_RUN && cnt_q == STEP_LAST,
		frc_x_q == '0 && frc_y_q == '0 && !wb_vld, "step left force sum or writeback pending")
	`PEI_ASSERT_NEXT(a_out_loaded, clk, arst_n, out_load,
		out_vld_q && state_q == ST_IDLE, "held item not moved to output register")

endmodule
